// ===== hdl/csv_pkg.sv =====
// shared constants, types and helpers for the curvature sampling variance block
package csv_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int MAX_DIMS    = 64;

  localparam int SAMP_AW  = $clog2(MAX_SAMPLES);
  localparam int SAMP_CW  = $clog2(MAX_SAMPLES + 1);
  localparam int DIM_AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIM_CW   = $clog2(MAX_DIMS + 1);
  localparam int SQ_DEPTH = MAX_SAMPLES * MAX_DIMS;
  localparam int SQ_AW    = $clog2(SQ_DEPTH);

  localparam int COST_W    = 32;
  localparam int NOISE_W   = 16;
  localparam int MAG_W     = 16;
  localparam int X_W       = 31;
  localparam int SCALE_W   = 16;
  localparam int STD_W     = 15;
  localparam int VAR_W     = 32;
  localparam int OUT_DIM_W = 6;
  localparam int CNT_W     = 7;

  // accumulator and product widths
  localparam int SC_W   = COST_W + SAMP_AW;
  localparam int SX_W   = X_W + SAMP_AW;
  localparam int SCX_W  = COST_W + X_W + SAMP_AW;
  localparam int SXX_W  = 2 * X_W + SAMP_AW;
  localparam int WIDE_W = SCX_W + SAMP_CW + 1;
  localparam int NUM_W  = WIDE_W + VAR_W;
  localparam int S2_W   = 2 * SCALE_W;
  localparam int MPL_W  = SX_W;
  localparam int DIVC_W = $clog2(VAR_W);

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PW    = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STD_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STD_CEILING  = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]   sample_count;
    logic [CNT_W-1:0]   dim_count;
    logic [SCALE_W-1:0] curvature_scale;
    logic [STD_W-1:0]   std_floor;
    logic [STD_W-1:0]   std_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [SAMP_CW-1:0] n;
    logic [DIM_CW-1:0]  dcount;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [SAMP_AW-1:0] sample;
    logic [DIM_AW-1:0]  dim;
    logic [COST_W-1:0]  cost;
    logic [X_W-1:0]     square;
  } ram_wr_t;

  function automatic logic [SQ_AW-1:0] sq_addr(input logic [SAMP_AW-1:0] sample,
                                               input logic [DIM_AW-1:0] dim);
    logic [SQ_AW-1:0] a;
    a = SQ_AW'(sample) * SQ_AW'(MAX_DIMS) + SQ_AW'(dim);
    return a;
  endfunction

endpackage

// ===== hdl/csv_ram.sv =====
// generic single-write, single-read ram with registered read data
module csv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/csv_fifo.sv =====
// short job queue between the load front and the compute back
module csv_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csv_pkg::job_t push_data,
  input  logic          pop,
  output csv_pkg::job_t pop_data,
  output logic          empty,
  output logic          full
);
  import csv_pkg::*;

  job_t              mem_r [JOB_DEPTH];
  logic [JOB_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_PW:0]   count_r;
  logic [JOB_PW-1:0] wr_ptr_nxt, rd_ptr_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == JOB_PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + JOB_PW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == JOB_PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + JOB_PW'(1);
  assign empty    = (count_r == '0);
  assign full     = (count_r == (JOB_PW + 1)'(JOB_DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= wr_ptr_nxt;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count_r <= count_r + (JOB_PW + 1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count_r <= count_r - (JOB_PW + 1)'(1);
      end
    end
  end

endmodule

// ===== hdl/csv_front.sv =====
// load front: tracks the load position, writes the stores, queues batch jobs
module csv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csv_pkg::cfg_t                       cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [csv_pkg::COST_W-1:0]   sample_cost,
  input  logic signed [csv_pkg::NOISE_W-1:0]  noise_value,
  input  logic                                batch_end,
  input  logic                                back_busy,
  input  logic                                job_empty,
  output logic                                job_push,
  output csv_pkg::job_t                       job,
  output csv_pkg::ram_wr_t                    wr
);
  import csv_pkg::*;

  logic [SAMP_CW-1:0]   load_sample_r, load_sample_nxt;
  logic [DIM_AW-1:0]    load_dim_r, load_dim_nxt;
  logic [DIM_CW-1:0]    dim_inc;
  logic [DIM_CW-1:0]    dcount;
  logic [SAMP_CW-1:0]   n_eff;
  logic [MAG_W-1:0]     mag;
  logic [2*MAG_W-1:0]   sq_full;
  logic                 accept;

  // memories are read by the back, so loading waits until it is done
  assign in_tready = job_empty && !back_busy;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (cfg.dim_count == '0) begin
      dcount = DIM_CW'(1);
    end else if (int'(cfg.dim_count) > MAX_DIMS) begin
      dcount = DIM_CW'(MAX_DIMS);
    end else begin
      dcount = DIM_CW'(cfg.dim_count);
    end
    if (int'(cfg.sample_count) > MAX_SAMPLES) begin
      n_eff = SAMP_CW'(MAX_SAMPLES);
    end else begin
      n_eff = SAMP_CW'(cfg.sample_count);
    end
  end

  assign mag     = noise_value[NOISE_W-1] ? ($unsigned(~noise_value) + MAG_W'(1))
                                          : $unsigned(noise_value);
  assign sq_full = mag * mag;

  assign wr.we     = accept && (load_sample_r < SAMP_CW'(MAX_SAMPLES));
  assign wr.sample = load_sample_r[SAMP_AW-1:0];
  assign wr.dim    = load_dim_r;
  assign wr.cost   = $unsigned(sample_cost);
  assign wr.square = sq_full[X_W-1:0];

  assign dim_inc = DIM_CW'(load_dim_r) + DIM_CW'(1);

  always_comb begin
    load_dim_nxt    = load_dim_r;
    load_sample_nxt = load_sample_r;
    if (dim_inc >= dcount) begin
      load_dim_nxt = '0;
      if (load_sample_r < SAMP_CW'(MAX_SAMPLES)) begin
        load_sample_nxt = load_sample_r + SAMP_CW'(1);
      end
    end else begin
      load_dim_nxt = dim_inc[DIM_AW-1:0];
    end
    if (batch_end) begin
      load_dim_nxt    = '0;
      load_sample_nxt = '0;
    end
  end

  // short batches only rewind the position
  assign job_push   = accept && batch_end && (n_eff >= SAMP_CW'(2));
  assign job.n      = n_eff;
  assign job.dcount = dcount;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_sample_r <= '0;
      load_dim_r    <= '0;
    end else if (accept) begin
      load_sample_r <= load_sample_nxt;
      load_dim_r    <= load_dim_nxt;
    end
  end

endmodule

// ===== hdl/csv_back.sv =====
// compute back: per-dimension sums, shift-add products, restoring divide, clamp
module csv_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csv_pkg::cfg_t                 cfg,
  input  logic                          job_empty,
  input  csv_pkg::job_t                 job,
  output logic                          job_pop,
  output logic [csv_pkg::SAMP_AW-1:0]   cost_raddr,
  input  logic [csv_pkg::COST_W-1:0]    cost_rdata,
  output logic [csv_pkg::SQ_AW-1:0]     sq_raddr,
  input  logic [csv_pkg::X_W-1:0]       sq_rdata,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csv_pkg::OUT_DIM_W-1:0] out_dim,
  output logic [csv_pkg::VAR_W-1:0]     out_var,
  output logic                          out_last
);
  import csv_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ACC     = 4'd1;
  localparam logic [3:0] ST_MUL_P   = 4'd2;
  localparam logic [3:0] ST_MUL_Q   = 4'd3;
  localparam logic [3:0] ST_MUL_P2  = 4'd4;
  localparam logic [3:0] ST_MUL_Q2  = 4'd5;
  localparam logic [3:0] ST_CHECK   = 4'd6;
  localparam logic [3:0] ST_MUL_NUM = 4'd7;
  localparam logic [3:0] ST_SAT     = 4'd8;
  localparam logic [3:0] ST_DIV     = 4'd9;
  localparam logic [3:0] ST_EMIT    = 4'd10;

  logic [3:0]            state_r;
  logic [SAMP_CW-1:0]    n_r, i_r;
  logic [DIM_CW-1:0]     dcount_r;
  logic [DIM_AW-1:0]     d_r;
  logic [S2_W-1:0]       s2_r;
  logic [VAR_W-1:0]      vmin_r, vmax_r, v_r;
  logic                  rv_r, mv_r;
  logic [COST_W+X_W-1:0] cx_r;
  logic [2*X_W-1:0]      xx_r;
  logic [COST_W-1:0]     cd_r;
  logic [X_W-1:0]        xd_r;
  logic [SC_W-1:0]       sc_r;
  logic [SX_W-1:0]       sx_r;
  logic [SCX_W-1:0]      scx_r;
  logic [SXX_W-1:0]      sxx_r;
  logic [WIDE_W-1:0]     p_r, q_r, p2_r, q2_r, den_r;
  logic [NUM_W-1:0]      mcand_r, acc_r, dsh_r;
  logic [MPL_W-1:0]      mplier_r;
  logic [VAR_W-1:0]      quo_r;
  logic [DIVC_W-1:0]     div_cnt_r;
  logic                  out_valid_r, out_last_r;
  logic [OUT_DIM_W-1:0]  out_dim_r;
  logic [VAR_W-1:0]      out_var_r;

  logic                  issue, mul_done, div_ge, is_last, out_free;
  logic [COST_W-1:0]     c_ofs;
  logic [VAR_W-1:0]      v_lo, v_clamp;
  logic [DIM_CW-1:0]     d_inc;

  assign busy     = (state_r != ST_IDLE);
  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign issue    = (state_r == ST_ACC) && (i_r < n_r);
  assign cost_raddr = i_r[SAMP_AW-1:0];
  assign sq_raddr   = sq_addr(i_r[SAMP_AW-1:0], d_r);
  // offset binary cost so all terms are unsigned
  assign c_ofs    = cost_rdata ^ {1'b1, {(COST_W-1){1'b0}}};
  assign mul_done = (mplier_r == '0);
  assign div_ge   = (acc_r >= dsh_r);
  assign d_inc    = DIM_CW'(d_r) + DIM_CW'(1);
  assign is_last  = (d_inc == dcount_r);
  assign out_free = !out_valid_r || out_ready;
  assign v_lo     = (v_r < vmin_r) ? vmin_r : v_r;
  assign v_clamp  = (v_lo > vmax_r) ? vmax_r : v_lo;

  assign out_valid = out_valid_r;
  assign out_dim   = out_dim_r;
  assign out_var   = out_var_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= issue;
      mv_r <= rv_r;
      if (out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (issue) begin
        i_r <= i_r + SAMP_CW'(1);
      end
      if (rv_r) begin
        cx_r <= c_ofs * sq_rdata;
        xx_r <= sq_rdata * sq_rdata;
        cd_r <= c_ofs;
        xd_r <= sq_rdata;
      end
      if (mv_r) begin
        sc_r  <= sc_r + SC_W'(cd_r);
        sx_r  <= sx_r + SX_W'(xd_r);
        scx_r <= scx_r + SCX_W'(cx_r);
        sxx_r <= sxx_r + SXX_W'(xx_r);
      end
      if (((state_r == ST_MUL_P) || (state_r == ST_MUL_Q) || (state_r == ST_MUL_P2) ||
           (state_r == ST_MUL_Q2) || (state_r == ST_MUL_NUM)) && !mul_done) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            n_r      <= job.n;
            dcount_r <= job.dcount;
            s2_r     <= cfg.curvature_scale * cfg.curvature_scale;
            vmin_r   <= VAR_W'(cfg.std_floor) * VAR_W'(cfg.std_floor);
            vmax_r   <= VAR_W'(cfg.std_ceiling) * VAR_W'(cfg.std_ceiling);
            d_r      <= '0;
            i_r      <= '0;
            sc_r     <= '0;
            sx_r     <= '0;
            scx_r    <= '0;
            sxx_r    <= '0;
            state_r  <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!issue && !rv_r && !mv_r) begin
            mcand_r  <= NUM_W'(scx_r);
            mplier_r <= MPL_W'(n_r);
            acc_r    <= '0;
            state_r  <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_done) begin
            p_r      <= WIDE_W'(acc_r);
            mcand_r  <= NUM_W'(sc_r);
            mplier_r <= MPL_W'(sx_r);
            acc_r    <= '0;
            state_r  <= ST_MUL_Q;
          end
        end
        ST_MUL_Q: begin
          if (mul_done) begin
            q_r      <= WIDE_W'(acc_r);
            mcand_r  <= NUM_W'(sxx_r);
            mplier_r <= MPL_W'(n_r);
            acc_r    <= '0;
            state_r  <= ST_MUL_P2;
          end
        end
        ST_MUL_P2: begin
          if (mul_done) begin
            p2_r     <= WIDE_W'(acc_r);
            mcand_r  <= NUM_W'(sx_r);
            mplier_r <= MPL_W'(sx_r);
            acc_r    <= '0;
            state_r  <= ST_MUL_Q2;
          end
        end
        ST_MUL_Q2: begin
          if (mul_done) begin
            q2_r    <= WIDE_W'(acc_r);
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // curvature must be positive with a positive spread
          if ((p2_r > q2_r) && (p_r > q_r)) begin
            mcand_r  <= NUM_W'(p2_r - q2_r);
            mplier_r <= MPL_W'(s2_r);
            acc_r    <= '0;
            den_r    <= (p_r - q_r) << 1;
            state_r  <= ST_MUL_NUM;
          end else begin
            v_r     <= vmax_r;
            state_r <= ST_EMIT;
          end
        end
        ST_MUL_NUM: begin
          if (mul_done) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (acc_r >= {den_r, {VAR_W{1'b0}}}) begin
            v_r     <= '1;
            state_r <= ST_EMIT;
          end else begin
            dsh_r     <= {1'b0, den_r, {(VAR_W-1){1'b0}}};
            quo_r     <= '0;
            div_cnt_r <= DIVC_W'(VAR_W - 1);
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            acc_r <= acc_r - dsh_r;
          end
          quo_r <= {quo_r[VAR_W-2:0], div_ge};
          dsh_r <= dsh_r >> 1;
          if (div_cnt_r == '0) begin
            v_r     <= {quo_r[VAR_W-2:0], div_ge};
            state_r <= ST_EMIT;
          end else begin
            div_cnt_r <= div_cnt_r - DIVC_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_dim_r   <= OUT_DIM_W'(d_r);
            out_var_r   <= v_clamp;
            out_last_r  <= is_last;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              d_r     <= d_inc[DIM_AW-1:0];
              i_r     <= '0;
              sc_r    <= '0;
              sx_r    <= '0;
              scx_r   <= '0;
              sxx_r   <= '0;
              state_r <= ST_ACC;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/curvature_sampling_variance_unit.sv =====
// top level of the curvature sampling variance block
//
// in_*: one noise element per transfer, sample-major (sample 0 dims 0..D-1, then
//   sample 1, ...), each with the cost of its sample; in_tlast marks the last element
//   of the batch. loading takes one element per clock while in_tready is high.
// out_*: one variance per dimension, in dimension order, after a batch whose
//   configured sample count is at least two; out_tlast marks the final dimension.
// cfg_*: register writes, taken every cycle; user writes only while idle, unchecked.
// after the closing element the back works through each dimension in turn:
//   accumulation through the store read ports and the multiply pipe, then the shared
//   shift-add multiplier (one multiplier bit per cycle) and, unless the check or
//   saturation settles the result, the restoring divider.
// in_tready stays low from the closing element until the last result has entered the
//   output register, since the stores are being read.
// reset (rst_n low, synchronous) restores register defaults, empties the job queue and
//   the output register; store contents are not cleared and no clearing pass is run.
// when the receiver stalls, the result holds in the output register and the back waits.
module curvature_sampling_variance_unit (
  input  logic        clk,
  input  logic        rst_n,
  // sample_cost [31:0], noise_value [47:32]
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // dim_index [5:0], sample_variance [37:6], zero pad [39:38]
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import csv_pkg::*;

  cfg_t                 cfg_r;
  job_t                 push_job, pop_job;
  logic                 job_push, job_pop, job_empty, job_full;
  ram_wr_t              wr;
  logic                 back_busy;
  logic [SAMP_AW-1:0]   cost_raddr;
  logic [COST_W-1:0]    cost_rdata;
  logic [SQ_AW-1:0]     sq_raddr;
  logic [X_W-1:0]       sq_rdata;
  logic [OUT_DIM_W-1:0] out_dim;
  logic [VAR_W-1:0]     out_var;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count    <= CNT_W'(10);
      cfg_r.dim_count       <= CNT_W'(64);
      cfg_r.curvature_scale <= SCALE_W'(256);
      cfg_r.std_floor       <= STD_W'(41);
      cfg_r.std_ceiling     <= STD_W'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: cfg_r.sample_count    <= cfg_data[CNT_W-1:0];
        REG_DIM_COUNT:    cfg_r.dim_count       <= cfg_data[CNT_W-1:0];
        REG_SCALE:        cfg_r.curvature_scale <= cfg_data[SCALE_W-1:0];
        REG_STD_FLOOR:    cfg_r.std_floor       <= cfg_data[STD_W-1:0];
        REG_STD_CEILING:  cfg_r.std_ceiling     <= cfg_data[STD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: position tracking and store writes
  csv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .sample_cost ($signed(in_tdata[31:0])),
    .noise_value ($signed(in_tdata[47:32])),
    .batch_end   (in_tlast),
    .back_busy   (back_busy),
    .job_empty   (job_empty),
    .job_push    (job_push),
    .job         (push_job),
    .wr          (wr)
  );

  // per-sample cost store
  csv_ram #(.WIDTH(COST_W), .DEPTH(MAX_SAMPLES)) u_cost_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.sample),
    .wdata (wr.cost),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  // squared noise store, sample-major rows of MAX_DIMS
  csv_ram #(.WIDTH(X_W), .DEPTH(SQ_DEPTH)) u_sq_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (sq_addr(wr.sample, wr.dim)),
    .wdata (wr.square),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // batch jobs waiting for the back
  csv_fifo u_jobs (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .empty     (job_empty),
    .full      (job_full)
  );

  // back: statistics, curvature, variance and the output register
  csv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_empty  (job_empty),
    .job        (pop_job),
    .job_pop    (job_pop),
    .cost_raddr (cost_raddr),
    .cost_rdata (cost_rdata),
    .sq_raddr   (sq_raddr),
    .sq_rdata   (sq_rdata),
    .busy       (back_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_dim    (out_dim),
    .out_var    (out_var),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_var, out_dim};

  // a batch end with a sample count of at least two blocks loading on the next cycle
  a_batch_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast && (cfg_r.sample_count >= CNT_W'(2)))
    |=> !in_tready)
    else $error("load not blocked after batch end");

  // after reset nothing is pending and loading is open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("state not clean after reset");

  // the job queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job queue overflow");

endmodule
